FILE: rtl/iphttp_pkg.sv
// Shared types, protocol constants and method tables for the IPv4 HTTP request filter.
`default_nettype none

package iphttp_pkg;

    // Ethernet and IPv4 field values
    localparam logic [15:0] TYPE_IPV4     = 16'h0800;
    localparam logic [15:0] TYPE_VLAN     = 16'h8100;
    localparam logic [15:0] IP_BASE_PLAIN = 16'd14;
    localparam logic [15:0] IP_BASE_VLAN  = 16'd18;
    localparam logic [3:0]  MIN_WORDS     = 4'd5;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [15:0] MIN_HDR_BYTES = 16'd20;
    localparam logic [1:0]  FRAG_MF_DF    = 2'b11;

    // Byte offsets within the frame
    localparam logic [15:0] OFF_TYPE_HI  = 16'd12;
    localparam logic [15:0] OFF_TYPE_LO  = 16'd13;
    localparam logic [15:0] OFF_INNER_HI = 16'd16;
    localparam logic [15:0] OFF_INNER_LO = 16'd17;

    // Byte offsets within the IPv4 header
    localparam logic [15:0] IP_OFF_IHL     = 16'd0;
    localparam logic [15:0] IP_OFF_TLEN_HI = 16'd2;
    localparam logic [15:0] IP_OFF_TLEN_LO = 16'd3;
    localparam logic [15:0] IP_OFF_FRAG    = 16'd6;
    localparam logic [15:0] IP_OFF_PROTO   = 16'd9;
    localparam logic [15:0] IP_OFF_SRC_LO  = 16'd12;
    localparam logic [15:0] IP_OFF_SRC_HI  = 16'd15;
    localparam logic [15:0] IP_OFF_DST_LO  = 16'd16;
    localparam logic [15:0] IP_OFF_DST_HI  = 16'd19;

    // Byte offset of the data offset field within the TCP header
    localparam logic [15:0] TCP_OFF_DOFF = 16'd12;

    // HTTP methods, in order of priority: GET, POST, HEAD, PUT
    localparam int NUM_METHODS  = 4;
    localparam int METH_MAX_LEN = 5;

    localparam logic [2:0] METHOD_NONE = 3'd0;
    localparam logic [2:0] METHOD_GET  = 3'd1;
    localparam logic [2:0] METHOD_POST = 3'd2;
    localparam logic [2:0] METHOD_HEAD = 3'd3;
    localparam logic [2:0] METHOD_PUT  = 3'd4;

    localparam logic [7:0] METH_TEXT [NUM_METHODS][METH_MAX_LEN] = '{
        '{8'h47, 8'h45, 8'h54, 8'h20, 8'h00},
        '{8'h50, 8'h4F, 8'h53, 8'h54, 8'h20},
        '{8'h48, 8'h45, 8'h41, 8'h44, 8'h20},
        '{8'h50, 8'h55, 8'h54, 8'h20, 8'h00}
    };
    localparam logic [2:0] METH_LEN  [NUM_METHODS] = '{3'd4, 3'd5, 3'd5, 3'd4};
    localparam logic [2:0] METH_CODE [NUM_METHODS] =
        '{METHOD_GET, METHOD_POST, METHOD_HEAD, METHOD_PUT};

    // Per-frame parse state
    typedef struct packed {
        logic [15:0]            byte_count;
        logic [15:0]            outer_type;
        logic [15:0]            inner_type;
        logic [3:0]             header_words;
        logic [15:0]            total_length;
        logic [1:0]             frag_flags;
        logic [7:0]             protocol_number;
        logic [31:0]            src_addr;
        logic [31:0]            dst_addr;
        logic [3:0]             tcp_words;
        logic [NUM_METHODS-1:0] method_hits;
    } t_frame_state;

    localparam t_frame_state STATE_RESET = '{
        method_hits: '1,
        default:     '0
    };

    // Verdict for one frame
    typedef struct packed {
        logic        verdict;
        logic [2:0]  http_method;
        logic        tcp_seen;
        logic [31:0] source_address;
        logic [31:0] destination_address;
    } t_result;

endpackage

`default_nettype wire

FILE: rtl/iphttp_if.sv
// Valid/ready channel interfaces for frame bytes in and frame verdicts out.
`default_nettype none

interface iphttp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] frame_byte;
    logic       frame_end;

    modport source (output valid, output frame_byte, output frame_end, input ready);
    modport sink   (input valid, input frame_byte, input frame_end, output ready);
endinterface

interface iphttp_out_if;
    logic        valid;
    logic        ready;
    logic        verdict;
    logic [2:0]  http_method;
    logic        tcp_seen;
    logic [31:0] source_address;
    logic [31:0] destination_address;

    modport source (output valid, output verdict, output http_method, output tcp_seen,
                    output source_address, output destination_address, input ready);
    modport sink   (input valid, input verdict, input http_method, input tcp_seen,
                    input source_address, input destination_address, output ready);
endinterface

`default_nettype wire

FILE: rtl/iphttp_decide.sv
// End-of-frame decision: layer-two, IPv4 header, TCP and HTTP method checks.
`default_nettype none

module iphttp_decide (
    input  var iphttp_pkg::t_frame_state i_state,
    output var iphttp_pkg::t_result      o_result
);

    logic        w_l2_ok;
    logic        w_hdr_ok;
    logic        w_tcp_full;
    logic        w_tcp_under;
    logic        w_tcp_seen;
    logic [15:0] w_base;
    logic [15:0] w_rem;
    logic [15:0] w_hl;
    logic [15:0] w_rem2;
    logic [15:0] w_tl;
    logic [15:0] w_pay;
    logic [2:0]  w_method;

    always_comb begin
        w_l2_ok = (i_state.byte_count > iphttp_pkg::IP_BASE_PLAIN) &&
                  ((i_state.outer_type == iphttp_pkg::TYPE_IPV4) ||
                   ((i_state.outer_type == iphttp_pkg::TYPE_VLAN) &&
                    (i_state.byte_count >= iphttp_pkg::IP_BASE_VLAN) &&
                    (i_state.inner_type == iphttp_pkg::TYPE_IPV4)));

        w_base = (i_state.outer_type == iphttp_pkg::TYPE_VLAN) ?
                 iphttp_pkg::IP_BASE_VLAN : iphttp_pkg::IP_BASE_PLAIN;
        w_rem  = i_state.byte_count - w_base;
        w_hl   = {10'd0, i_state.header_words, 2'b00};

        w_hdr_ok = (w_rem >= iphttp_pkg::MIN_HDR_BYTES) &&
                   (i_state.header_words >= iphttp_pkg::MIN_WORDS) &&
                   (i_state.total_length >= w_hl) &&
                   (i_state.frag_flags != iphttp_pkg::FRAG_MF_DF) &&
                   (w_rem >= w_hl) &&
                   (i_state.src_addr != 32'd0) &&
                   (i_state.dst_addr != 32'd0);

        w_rem2      = w_rem - w_hl;
        w_tl        = {10'd0, i_state.tcp_words, 2'b00};
        w_tcp_full  = (i_state.protocol_number == iphttp_pkg::PROTO_TCP) &&
                      (w_rem2 >= iphttp_pkg::MIN_HDR_BYTES);
        w_tcp_under = (w_tl > w_rem2);
        w_pay       = w_rem2 - w_tl;

        // Lowest index has priority, so scan from the top and let it win last.
        w_method = iphttp_pkg::METHOD_NONE;
        for (int k = iphttp_pkg::NUM_METHODS - 1; k >= 0; k--) begin
            if (i_state.method_hits[k] && (w_pay >= {13'd0, iphttp_pkg::METH_LEN[k]})) begin
                w_method = iphttp_pkg::METH_CODE[k];
            end
        end

        w_tcp_seen = w_l2_ok && w_hdr_ok && w_tcp_full && !w_tcp_under;

        o_result.verdict             = !(w_l2_ok && w_hdr_ok && !(w_tcp_full && w_tcp_under));
        o_result.tcp_seen            = w_tcp_seen;
        o_result.http_method         = (w_tcp_seen &&
                                        (i_state.tcp_words >= iphttp_pkg::MIN_WORDS)) ?
                                       w_method : iphttp_pkg::METHOD_NONE;
        o_result.source_address      = w_l2_ok ? i_state.src_addr : 32'd0;
        o_result.destination_address = w_l2_ok ? i_state.dst_addr : 32'd0;
    end

endmodule

`default_nettype wire

FILE: rtl/ipv4_http_request_filter.sv
// Top level of the IPv4 HTTP request filter: byte capture, header parse and verdict output.
`default_nettype none

// The filter takes an Ethernet frame one byte per transaction, from the destination
// MAC onward, with frame_end set on the last captured byte. It accepts untagged IPv4
// or IPv4 behind a single VLAN tag, checks the IPv4 header (length, IHL, total
// length, both MF and DF set, zero addresses) and, for a TCP frame, whether the TCP
// payload starts with GET, POST, HEAD or PUT. Exactly one result transaction is
// produced per frame, carrying the verdict, method and addresses; no transaction is
// produced for the other bytes. The block sustains one byte per clock cycle: each
// byte passes through an input register and then a single stage of field capture
// and decision logic into the result register, where the result of a frame is
// captured once its last byte leaves the input register. Input is held off only
// while a frame's last byte waits behind a result that has not yet been taken.
// Frames longer than 65535 bytes are handled, as bytes beyond that count are
// ignored.
module ipv4_http_request_filter (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    iphttp_in_if.sink             i_frame,
    iphttp_out_if.source          o_result
);

    // Input register
    logic       r_in_valid;
    logic [7:0] r_byte;
    logic       r_end;

    // Frame parse state and result register
    iphttp_pkg::t_frame_state r_state;
    iphttp_pkg::t_frame_state n_state;
    iphttp_pkg::t_result      r_result;
    iphttp_pkg::t_result      w_result;
    logic                     r_out_valid;

    logic        w_in_ready;
    logic        w_adv;
    logic [15:0] w_base;
    logic [15:0] w_r;
    logic [15:0] w_hl;
    logic [15:0] w_t;
    logic [15:0] w_tl;
    logic [15:0] w_q;
    logic [1:0]  w_lane;

    // The held byte moves on unless it closes a frame and the result register is
    // still occupied by a result that is not being taken this cycle.
    assign w_adv      = r_in_valid && (!r_end || !r_out_valid || o_result.ready);
    assign w_in_ready = !r_in_valid || w_adv;

    assign i_frame.ready = w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (w_in_ready) begin
            r_in_valid <= i_frame.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_ready && i_frame.valid) begin
            r_byte <= i_frame.frame_byte;
            r_end  <= i_frame.frame_end;
        end
    end

    // Field capture for the held byte. Fields are taken at fixed offsets from the
    // frame start, from the IPv4 header base and from the TCP header start.
    always_comb begin
        n_state = r_state;
        w_base  = (r_state.outer_type == iphttp_pkg::TYPE_VLAN) ?
                  iphttp_pkg::IP_BASE_VLAN : iphttp_pkg::IP_BASE_PLAIN;
        w_r     = r_state.byte_count - w_base;
        w_hl    = {10'd0, r_state.header_words, 2'b00};
        w_t     = w_r - w_hl;
        w_tl    = {10'd0, r_state.tcp_words, 2'b00};
        w_q     = w_t - w_tl;
        w_lane  = ~w_r[1:0];

        if (r_state.byte_count == iphttp_pkg::OFF_TYPE_HI) begin
            n_state.outer_type[15:8] = r_byte;
        end
        if (r_state.byte_count == iphttp_pkg::OFF_TYPE_LO) begin
            n_state.outer_type[7:0] = r_byte;
        end
        if (w_base == iphttp_pkg::IP_BASE_VLAN) begin
            if (r_state.byte_count == iphttp_pkg::OFF_INNER_HI) begin
                n_state.inner_type[15:8] = r_byte;
            end
            if (r_state.byte_count == iphttp_pkg::OFF_INNER_LO) begin
                n_state.inner_type[7:0] = r_byte;
            end
        end

        if (r_state.byte_count >= w_base) begin
            if (w_r == iphttp_pkg::IP_OFF_IHL) begin
                n_state.header_words = r_byte[3:0];
            end
            if (w_r == iphttp_pkg::IP_OFF_TLEN_HI) begin
                n_state.total_length[15:8] = r_byte;
            end
            if (w_r == iphttp_pkg::IP_OFF_TLEN_LO) begin
                n_state.total_length[7:0] = r_byte;
            end
            if (w_r == iphttp_pkg::IP_OFF_FRAG) begin
                n_state.frag_flags = {r_byte[6], r_byte[5]};
            end
            if (w_r == iphttp_pkg::IP_OFF_PROTO) begin
                n_state.protocol_number = r_byte;
            end
            // Addresses arrive most significant byte first.
            if ((w_r >= iphttp_pkg::IP_OFF_SRC_LO) && (w_r <= iphttp_pkg::IP_OFF_SRC_HI)) begin
                n_state.src_addr[{w_lane, 3'b000} +: 8] = r_byte;
            end
            if ((w_r >= iphttp_pkg::IP_OFF_DST_LO) && (w_r <= iphttp_pkg::IP_OFF_DST_HI)) begin
                n_state.dst_addr[{w_lane, 3'b000} +: 8] = r_byte;
            end

            if ((r_state.header_words >= iphttp_pkg::MIN_WORDS) &&
                (r_state.protocol_number == iphttp_pkg::PROTO_TCP) && (w_r >= w_hl)) begin
                if (w_t == iphttp_pkg::TCP_OFF_DOFF) begin
                    n_state.tcp_words = r_byte[7:4];
                end
                // Compare payload bytes against every method string at once; a
                // mismatch knocks that method out for the rest of the frame.
                if ((r_state.tcp_words >= iphttp_pkg::MIN_WORDS) && (w_t >= w_tl) &&
                    (w_q < 16'(iphttp_pkg::METH_MAX_LEN))) begin
                    for (int k = 0; k < iphttp_pkg::NUM_METHODS; k++) begin
                        if ((w_q[2:0] < iphttp_pkg::METH_LEN[k]) &&
                            (r_byte != iphttp_pkg::METH_TEXT[k][w_q[2:0]])) begin
                            n_state.method_hits[k] = 1'b0;
                        end
                    end
                end
            end
        end

        if (r_state.byte_count != 16'hFFFF) begin
            n_state.byte_count = r_state.byte_count + 16'd1;
        end
    end

    iphttp_decide u_decide (
        .i_state  (n_state),
        .o_result (w_result)
    );

    // Parse state returns to its initial value after every frame.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= iphttp_pkg::STATE_RESET;
        end else if (w_adv) begin
            r_state <= r_end ? iphttp_pkg::STATE_RESET : n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv && r_end) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && r_end) begin
            r_result <= w_result;
        end
    end

    assign o_result.valid               = r_out_valid;
    assign o_result.verdict             = r_result.verdict;
    assign o_result.http_method         = r_result.http_method;
    assign o_result.tcp_seen            = r_result.tcp_seen;
    assign o_result.source_address      = r_result.source_address;
    assign o_result.destination_address = r_result.destination_address;

endmodule

`default_nettype wire
